>>> rtl/core/scbp_pkg.sv
// shared types, constants and helpers of the size class buffer pool
`timescale 1ns / 1ps
`default_nettype none
package scbp_pkg;

   localparam int MAX_CLASSES        = 4;
   localparam int MAX_QUEUES         = 8;
   localparam int MAX_BUFS_PER_QUEUE = 64;
   localparam int NUM_LISTS          = MAX_CLASSES * MAX_QUEUES;
   localparam int NUM_LINKS          = NUM_LISTS * MAX_BUFS_PER_QUEUE;

   // op codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REBUILD = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_CLASS  = 2'd1;
   localparam logic [1:0] ST_NO_BUFFER = 2'd2;
   localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_CLASS_COUNT = 3'd0;
   localparam logic [2:0] REG_QUEUES      = 3'd1;
   localparam logic [2:0] REG_BUFFERS     = 3'd2;
   localparam logic [2:0] REG_SIZE_0      = 3'd3;
   localparam logic [2:0] REG_SIZE_1      = 3'd4;
   localparam logic [2:0] REG_SIZE_2      = 3'd5;
   localparam logic [2:0] REG_SIZE_3      = 3'd6;

   typedef struct packed {
      logic [1:0]  op;
      logic [19:0] request_length;
      logic [1:0]  free_class;
      logic [2:0]  free_queue;
      logic [5:0]  free_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] granted_class;
      logic [2:0] granted_queue;
      logic [5:0] granted_index;
   } rsp_type;

   // buffers of one queue: base share, one more for queues below the remainder, capped at 64
   function automatic logic [6:0] queue_share(input logic [9:0] base,
                                              input logic [3:0] rem,
                                              input logic [2:0] q);
      logic [10:0] sum;
      sum = {1'b0, base} + {10'd0, ({1'b0, q} < rem)};
      if (sum > 11'(MAX_BUFS_PER_QUEUE)) begin
         return 7'(MAX_BUFS_PER_QUEUE);
      end
      return sum[6:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/scbp_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module scbp_div (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [9:0] dividend,
   input  wire logic [3:0] divisor,
   output logic            done,
   output logic [9:0]      quotient,
   output logic [3:0]      remainder
);
   logic [9:0] acc_ff, acc_in;
   logic [3:0] rem_ff, rem_in;
   logic [3:0] dsr_ff;
   logic [3:0] cnt_ff;
   logic       run_ff, done_ff;
   logic [4:0] trial;
   logic       ge;

   always_comb begin
      trial  = {rem_ff, acc_ff[9]};
      ge     = trial >= {1'b0, dsr_ff};
      rem_in = ge ? 4'(trial - {1'b0, dsr_ff}) : trial[3:0];
      acc_in = {acc_ff[8:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // pulse after the last quotient bit
         done_ff <= !start && run_ff && (cnt_ff == 4'd9);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> rtl/core/size_class_buffer_pool.sv
// top level of the size class buffer pool: registers, sequencer, list state
// allocate goes through dispatch, the class scan, the queue sweep and the pop to the result strobe
// free waits for the shared divider to give the queue share, then appends the handle
// rebuild walks all 32 lists, visiting each list and then linking each of its buffers
// one word at a time: busy drops with the result strobe, next word taken then; no stall
// synchronous reset empties every free list; link_mem holds garbage until written by a rebuild or a free
`timescale 1ns / 1ps
`default_nettype none
module size_class_buffer_pool (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire scbp_pkg::req_type req_payload,
   output logic                 rsp_valid,
   output scbp_pkg::rsp_type    rsp_payload,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [4:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DISP    = 4'd1;
   localparam logic [3:0] S_CLS     = 4'd2;
   localparam logic [3:0] S_SWEEP   = 4'd3;
   localparam logic [3:0] S_POP     = 4'd4;
   localparam logic [3:0] S_DIVW    = 4'd5;
   localparam logic [3:0] S_FREE    = 4'd6;
   localparam logic [3:0] S_RB_LIST = 4'd7;
   localparam logic [3:0] S_RB_LINK = 4'd8;

   // configuration registers
   logic [2:0]  class_count_ff;
   logic [3:0]  queues_ff;
   logic [9:0]  buffers_ff;
   logic [19:0] size_ff [4];
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= 3'd1;
         queues_ff      <= 4'd1;
         buffers_ff     <= 10'd64;
         size_ff[0]     <= 20'd1024;
         size_ff[1]     <= 20'd8192;
         size_ff[2]     <= 20'd65536;
         size_ff[3]     <= 20'd1048575;
      end else if (csr_write) begin
         unique case (csr_index)
            scbp_pkg::REG_CLASS_COUNT: class_count_ff <= pwdata[2:0];
            scbp_pkg::REG_QUEUES:      queues_ff      <= pwdata[3:0];
            scbp_pkg::REG_BUFFERS:     buffers_ff     <= pwdata[9:0];
            scbp_pkg::REG_SIZE_0:      size_ff[0]     <= pwdata[19:0];
            scbp_pkg::REG_SIZE_1:      size_ff[1]     <= pwdata[19:0];
            scbp_pkg::REG_SIZE_2:      size_ff[2]     <= pwdata[19:0];
            scbp_pkg::REG_SIZE_3:      size_ff[3]     <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         scbp_pkg::REG_CLASS_COUNT: prdata = {29'd0, class_count_ff};
         scbp_pkg::REG_QUEUES:      prdata = {28'd0, queues_ff};
         scbp_pkg::REG_BUFFERS:     prdata = {22'd0, buffers_ff};
         scbp_pkg::REG_SIZE_0:      prdata = {12'd0, size_ff[0]};
         scbp_pkg::REG_SIZE_1:      prdata = {12'd0, size_ff[1]};
         scbp_pkg::REG_SIZE_2:      prdata = {12'd0, size_ff[2]};
         scbp_pkg::REG_SIZE_3:      prdata = {12'd0, size_ff[3]};
         default:                   prdata = '0;
      endcase
   end

   // clamped class and queue counts
   logic [2:0] nc;
   logic [3:0] nq;
   always_comb begin
      nc = class_count_ff;
      if (nc == 3'd0) nc = 3'd1;
      if (nc > 3'd4) nc = 3'd4;
      nq = queues_ff;
      if (nq == 4'd0) nq = 4'd1;
      if (nq > 4'd8) nq = 4'd8;
   end

   // sequencer and list state
   logic [3:0]  state_ff;
   scbp_pkg::req_type item_ff;
   logic [1:0]  cls_ff;
   logic [2:0]  q_ff;
   logic [2:0]  t_ff;
   logic [4:0]  list_ff;
   logic [5:0]  idx_ff;
   logic [6:0]  n_ff;
   logic [5:0]  head_ff [scbp_pkg::NUM_LISTS];
   logic [5:0]  tail_ff [scbp_pkg::NUM_LISTS];
   logic [6:0]  cnt_ff  [scbp_pkg::NUM_LISTS];
   logic [2:0]  rr_ff   [scbp_pkg::MAX_CLASSES];
   logic        rsp_valid_ff;
   scbp_pkg::rsp_type rsp_ff;

   // shared divider for the queue share
   logic       div_start, div_done;
   logic [9:0] div_quot;
   logic [3:0] div_rem;

   scbp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (buffers_ff),
      .divisor   (nq),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // link memory
   logic [5:0]  link_mem [scbp_pkg::NUM_LINKS];
   logic        mem_we, mem_re;
   logic [10:0] mem_waddr, mem_raddr;
   logic [5:0]  mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= link_mem[mem_raddr];
   end

   // per-state helpers
   logic [4:0] sw_list, fr_list;
   logic [3:0] q_next;
   logic [6:0] fr_share, rb_share, rb_n;
   logic       fr_bad, rb_active, cls_hit;
   logic [2:0] rr_start;

   always_comb begin
      sw_list   = {cls_ff, q_ff};
      q_next    = ({1'b0, q_ff} + 4'd1 < nq) ? {1'b0, q_ff} + 4'd1 : 4'd0;
      cls_hit   = item_ff.request_length <= size_ff[cls_ff];
      rr_start  = ({1'b0, rr_ff[cls_ff]} >= nq) ? 3'd0 : rr_ff[cls_ff];
      fr_list   = {item_ff.free_class, item_ff.free_queue};
      fr_share  = scbp_pkg::queue_share(div_quot, div_rem, item_ff.free_queue);
      fr_bad    = ({1'b0, item_ff.free_class} >= nc) || ({1'b0, item_ff.free_queue} >= nq)
                  || ({1'b0, item_ff.free_index} >= fr_share)
                  || (cnt_ff[fr_list] >= fr_share);
      rb_share  = scbp_pkg::queue_share(div_quot, div_rem, list_ff[2:0]);
      rb_active = ({1'b0, list_ff[4:3]} < nc) && ({1'b0, list_ff[2:0]} < nq);
      rb_n      = rb_active ? rb_share : 7'd0;
   end

   // memory port use: free appends, rebuild links, allocate reads the head's link
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {fr_list, tail_ff[fr_list]};
      mem_wdata = item_ff.free_index;
      mem_re    = 1'b0;
      mem_raddr = {sw_list, head_ff[sw_list]};
      div_start = 1'b0;
      unique case (state_ff)
         S_DISP: begin
            div_start = (item_ff.op == scbp_pkg::OP_FREE)
                        || (item_ff.op == scbp_pkg::OP_REBUILD);
         end
         S_FREE: begin
            mem_we = !fr_bad && (cnt_ff[fr_list] != 7'd0);
         end
         S_RB_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = {list_ff, idx_ff};
            mem_wdata = ({1'b0, idx_ff} + 7'd1 == n_ff) ? 6'd0 : idx_ff + 6'd1;
         end
         S_SWEEP: begin
            mem_re = cnt_ff[sw_list] != 7'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < scbp_pkg::NUM_LISTS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         for (int i = 0; i < scbp_pkg::MAX_CLASSES; i++) begin
            rr_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               // strobe only ever rises on the way back to idle
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  item_ff  <= req_payload;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               cls_ff <= '0;
               unique case (item_ff.op)
                  scbp_pkg::OP_ALLOC: state_ff <= S_CLS;
                  scbp_pkg::OP_FREE:  state_ff <= S_DIVW;
                  scbp_pkg::OP_REBUILD: begin
                     for (int i = 0; i < scbp_pkg::MAX_CLASSES; i++) begin
                        rr_ff[i] <= '0;
                     end
                     state_ff <= S_DIVW;
                  end
                  default: begin
                     // undefined op answers ok and changes nothing
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            S_CLS: begin
               if (cls_hit) begin
                  q_ff     <= rr_start;
                  t_ff     <= '0;
                  state_ff <= S_SWEEP;
               end else if ({1'b0, cls_ff} + 3'd1 == nc) begin
                  rsp_ff       <= scbp_pkg::rsp_type'({scbp_pkg::ST_NO_CLASS, 11'd0});
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  cls_ff <= cls_ff + 2'd1;
               end
            end
            S_SWEEP: begin
               rr_ff[cls_ff] <= q_next[2:0];
               if (cnt_ff[sw_list] != 7'd0) begin
                  state_ff <= S_POP;
               end else if ({1'b0, t_ff} + 4'd1 == nq) begin
                  rsp_ff       <= scbp_pkg::rsp_type'({scbp_pkg::ST_NO_BUFFER, 11'd0});
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  q_ff <= q_next[2:0];
                  t_ff <= t_ff + 3'd1;
               end
            end
            S_POP: begin
               head_ff[sw_list]     <= mem_rdata_ff;
               cnt_ff[sw_list]      <= cnt_ff[sw_list] - 7'd1;
               rsp_ff.status        <= scbp_pkg::ST_OK;
               rsp_ff.granted_class <= cls_ff;
               rsp_ff.granted_queue <= q_ff;
               rsp_ff.granted_index <= head_ff[sw_list];
               rsp_valid_ff         <= 1'b1;
               state_ff             <= S_IDLE;
            end
            S_DIVW: begin
               if (div_done) begin
                  list_ff  <= '0;
                  state_ff <= (item_ff.op == scbp_pkg::OP_FREE) ? S_FREE : S_RB_LIST;
               end
            end
            S_FREE: begin
               rsp_ff <= fr_bad ? scbp_pkg::rsp_type'({scbp_pkg::ST_BAD_HANDLE, 11'd0})
                                : scbp_pkg::rsp_type'(13'd0);
               if (!fr_bad) begin
                  if (cnt_ff[fr_list] == 7'd0) head_ff[fr_list] <= item_ff.free_index;
                  tail_ff[fr_list] <= item_ff.free_index;
                  cnt_ff[fr_list]  <= cnt_ff[fr_list] + 7'd1;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_RB_LIST: begin
               head_ff[list_ff] <= '0;
               tail_ff[list_ff] <= (rb_n != 7'd0) ? 6'(rb_n - 7'd1) : 6'd0;
               cnt_ff[list_ff]  <= rb_n;
               n_ff             <= rb_n;
               idx_ff           <= '0;
               if (rb_n != 7'd0) begin
                  state_ff <= S_RB_LINK;
               end else if (list_ff == 5'(scbp_pkg::NUM_LISTS - 1)) begin
                  rsp_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  list_ff <= list_ff + 5'd1;
               end
            end
            S_RB_LINK: begin
               if ({1'b0, idx_ff} + 7'd1 == n_ff) begin
                  if (list_ff == 5'(scbp_pkg::NUM_LISTS - 1)) begin
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     list_ff  <= list_ff + 5'd1;
                     state_ff <= S_RB_LIST;
                  end
               end else begin
                  idx_ff <= idx_ff + 6'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy        = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

>>> rtl/core/scbp_checker.sv
// port-level checker for the size class buffer pool, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module scbp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire scbp_pkg::rsp_type rsp_payload,
   input wire logic              rsp_valid
);
   // every accepted word raises busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");

   // a result strobe lasts exactly one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   // busy only drops together with a result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a result");

   // failed results carry zero grant fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != scbp_pkg::ST_OK |->
      rsp_payload.granted_class == 2'd0 && rsp_payload.granted_queue == 3'd0
      && rsp_payload.granted_index == 6'd0) else $error("grant fields set on failure");
endmodule

bind size_class_buffer_pool scbp_checker u_scbp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_payload (rsp_payload),
   .rsp_valid   (rsp_valid)
);
`default_nettype wire
